>>> hw/rtl/bcc_pkg.sv
// Shared types, constants, BCD conversion functions and the month-length function for the BCD calendar clock.
package bcc_pkg;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_SET  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic CFG_TICK_INCREMENT = 1'b0;
    localparam logic CFG_TICK_PERIOD    = 1'b1;

    localparam logic [9:0]  TICK_INCREMENT_RESET = 10'd10;
    localparam logic [9:0]  TICK_PERIOD_RESET    = 10'd564;
    localparam logic [15:0] YEAR_RESET           = 16'd1980;
    localparam logic [6:0]  YEAR_MOD_RESET       = 7'd80;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] set_year_bcd;
        logic [7:0] set_month_week;
        logic [7:0] set_day_bcd;
        logic [7:0] set_hour_bcd;
        logic [7:0] set_minute_bcd;
        logic [7:0] set_second_bcd;
    } req_t;

    typedef struct packed {
        logic [7:0] year_bcd;
        logic [7:0] month_week;
        logic [7:0] day_bcd;
        logic [7:0] hour_bcd;
        logic [7:0] minute_bcd;
        logic [7:0] second_bcd;
    } rsp_t;

    // binary time snapshot handed to the output formatter
    typedef struct packed {
        logic [6:0] year_mod;
        logic [3:0] month;
        logic [3:0] weekday;
        logic [6:0] day;
        logic [6:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
    } cal_t;

    // high nibble * 10 + low nibble, no digit check
    function automatic logic [7:0] from_bcd(input logic [7:0] b);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = {4'b0000, b[7:4]};
        lo = {4'b0000, b[3:0]};
        return hi * 8'd10 + lo;
    endfunction

    // (v / 10) * 16 + v % 10, low 8 bits; divide by reciprocal 205 / 2048
    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [15:0] prod;
        logic [4:0]  q;
        logic [7:0]  r;
        prod = {8'b0, v} * 16'd205;
        q    = prod[15:11];
        r    = v - {3'b000, q} * 8'd10;
        return {q[3:0], r[3:0]};
    endfunction

    function automatic logic [4:0] month_limit(input logic [3:0] m, input logic leap);
        logic [4:0] lim;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: lim = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    lim = 5'd30;
            4'd2:                                       lim = leap ? 5'd29 : 5'd28;
            default:                                    lim = 5'd30;
        endcase
        return lim;
    endfunction

endpackage

>>> hw/rtl/bcd_calendar_clock.sv
// Top level of the BCD calendar clock.
//
//  channel  | valid      | stall      | payload
//  ---------+------------+------------+-----------------------------
//  request  | req_valid  | req_stall  | req (bcc_pkg::req_t)
//  result   | rsp_valid  | rsp_stall  | rsp (bcc_pkg::rsp_t)
//  config   | cfg_we     | -          | cfg_index, cfg_data
//
// One request per cycle while req_stall is low; its result is registered in turn by the input
// register, the calendar state update and the BCD result register.
// rst_n clears control state and loads the calendar to 1980-01-01 00:00:00,
// increment 10, period 564.
// A stalled result holds each stage in turn; req_stall rises once all are full.
module bcd_calendar_clock (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [9:0]    cfg_data,
    input  logic          req_valid,
    output logic          req_stall,
    input  bcc_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bcc_pkg::rsp_t rsp
);

    logic          cmd_valid;
    bcc_pkg::req_t cmd_req;
    logic          take;
    logic          out_ready;
    logic          cal_valid;
    bcc_pkg::cal_t cal;

    bcc_cmd_stage u_cmd_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .take      (take),
        .cmd_valid (cmd_valid),
        .cmd_req   (cmd_req)
    );

    bcc_time_core u_time_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_req   (cmd_req),
        .take      (take),
        .out_ready (out_ready),
        .cal_valid (cal_valid),
        .cal       (cal)
    );

    bcc_bcd_out u_bcd_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .cal_valid (cal_valid),
        .cal       (cal),
        .out_ready (out_ready),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

>>> hw/rtl/bcc_cmd_stage.sv
// Input register stage for the BCD calendar clock requests.
module bcc_cmd_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bcc_pkg::req_t req,
    input  logic          take,
    output logic          cmd_valid,
    output bcc_pkg::req_t cmd_req
);

    logic          valid_reg;
    logic          valid_next;
    bcc_pkg::req_t req_reg;
    logic          ready;
    logic          load;

    assign ready      = !valid_reg || take;
    assign req_stall  = !ready;
    assign load       = req_valid && ready;
    assign valid_next = load || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg <= req;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd_req   = req_reg;

endmodule

>>> hw/rtl/bcc_time_core.sv
// Prescaler, calendar state and configuration registers of the BCD calendar clock.
module bcc_time_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [9:0]    cfg_data,
    input  logic          cmd_valid,
    input  bcc_pkg::req_t cmd_req,
    output logic          take,
    input  logic          out_ready,
    output logic          cal_valid,
    output bcc_pkg::cal_t cal
);

    logic [9:0]  tick_increment_reg;
    logic [9:0]  tick_period_reg;
    logic [10:0] prescale_reg;
    logic [15:0] year_reg;
    logic [6:0]  year_mod_reg;
    logic [3:0]  month_reg;
    logic [3:0]  weekday_reg;
    logic [6:0]  day_reg;
    logic [6:0]  hour_reg;
    logic [7:0]  minute_reg;
    logic [7:0]  second_reg;
    logic        cal_valid_reg;

    logic [10:0] prescale_next;
    logic [15:0] year_next;
    logic [6:0]  year_mod_next;
    logic [3:0]  month_next;
    logic [3:0]  weekday_next;
    logic [6:0]  day_next;
    logic [6:0]  hour_next;
    logic [7:0]  minute_next;
    logic [7:0]  second_next;
    logic        cal_valid_next;

    logic        advance;
    logic [11:0] sum;
    logic [11:0] sum_less;
    logic        sec_step;
    logic        sec_wrap;
    logic        min_wrap;
    logic        hour_wrap;
    logic        day_wrap;
    logic        leap;
    logic [4:0]  limit;
    logic [4:0]  wk_inc;
    logic [7:0]  set_year;
    logic [7:0]  set_day;
    logic [7:0]  set_hour;
    logic [7:0]  year_mod_wide;

    assign take           = !cal_valid_reg || out_ready;
    assign advance        = cmd_valid && take;
    assign cal_valid_next = advance || (cal_valid_reg && !out_ready);

    always_comb
    begin
        sum           = {1'b0, prescale_reg} + {2'b00, tick_increment_reg};
        sum_less      = sum - {2'b00, tick_period_reg};
        sec_step      = sum >= {2'b00, tick_period_reg};
        sec_wrap      = second_reg >= 8'd59;
        min_wrap      = sec_wrap && (minute_reg >= 8'd59);
        hour_wrap     = min_wrap && (hour_reg >= 7'd23);
        leap          = year_reg[1:0] == 2'b00;
        limit         = bcc_pkg::month_limit(month_reg, leap);
        day_wrap      = hour_wrap && (day_reg >= {2'b00, limit});
        wk_inc        = {1'b0, weekday_reg} + 5'd1;
        set_year      = bcc_pkg::from_bcd(cmd_req.set_year_bcd);
        set_day       = bcc_pkg::from_bcd(cmd_req.set_day_bcd);
        set_hour      = bcc_pkg::from_bcd(cmd_req.set_hour_bcd);
        year_mod_wide = (set_year >= 8'd100) ? (set_year - 8'd100) : set_year;

        prescale_next = prescale_reg;
        year_next     = year_reg;
        year_mod_next = year_mod_reg;
        month_next    = month_reg;
        weekday_next  = weekday_reg;
        day_next      = day_reg;
        hour_next     = hour_reg;
        minute_next   = minute_reg;
        second_next   = second_reg;

        case (cmd_req.cmd)
            bcc_pkg::CMD_TICK:
            begin
                if (!sec_step)
                begin
                    prescale_next = sum[10:0];
                end
                else
                begin
                    prescale_next = sum_less[10:0];
                    second_next   = sec_wrap ? 8'd0 : second_reg + 8'd1;
                    if (sec_wrap)
                    begin
                        minute_next = min_wrap ? 8'd0 : minute_reg + 8'd1;
                    end
                    if (min_wrap)
                    begin
                        hour_next = hour_wrap ? 7'd0 : hour_reg + 7'd1;
                    end
                    if (hour_wrap)
                    begin
                        if (wk_inc >= 5'd14)
                        begin
                            weekday_next = 4'(wk_inc - 5'd14);
                        end
                        else if (wk_inc >= 5'd7)
                        begin
                            weekday_next = 4'(wk_inc - 5'd7);
                        end
                        else
                        begin
                            weekday_next = wk_inc[3:0];
                        end
                        day_next = day_wrap ? 7'd1 : day_reg + 7'd1;
                    end
                    if (day_wrap)
                    begin
                        if (month_reg >= 4'd12)
                        begin
                            month_next = 4'd1;
                            year_next  = year_reg + 16'd1;
                            if (year_reg == 16'hffff || year_mod_reg >= 7'd99)
                            begin
                                year_mod_next = 7'd0;
                            end
                            else
                            begin
                                year_mod_next = year_mod_reg + 7'd1;
                            end
                        end
                        else
                        begin
                            month_next = month_reg + 4'd1;
                        end
                    end
                end
            end
            bcc_pkg::CMD_SET:
            begin
                // two-digit years below 80 land in 20xx
                year_next     = (set_year < 8'd80) ? 16'd2000 + {8'b0, set_year}
                                                   : 16'd1900 + {8'b0, set_year};
                year_mod_next = year_mod_wide[6:0];
                month_next    = cmd_req.set_month_week[7:4];
                weekday_next  = cmd_req.set_month_week[3:0];
                day_next      = set_day[6:0];
                hour_next     = set_hour[6:0];
                minute_next   = bcc_pkg::from_bcd(cmd_req.set_minute_bcd);
                second_next   = bcc_pkg::from_bcd(cmd_req.set_second_bcd);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_increment_reg <= bcc_pkg::TICK_INCREMENT_RESET;
            tick_period_reg    <= bcc_pkg::TICK_PERIOD_RESET;
            prescale_reg       <= 11'd0;
            year_reg           <= bcc_pkg::YEAR_RESET;
            year_mod_reg       <= bcc_pkg::YEAR_MOD_RESET;
            month_reg          <= 4'd1;
            weekday_reg        <= 4'd0;
            day_reg            <= 7'd1;
            hour_reg           <= 7'd0;
            minute_reg         <= 8'd0;
            second_reg         <= 8'd0;
            cal_valid_reg      <= 1'b0;
        end
        else
        begin
            cal_valid_reg <= cal_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    bcc_pkg::CFG_TICK_INCREMENT: tick_increment_reg <= cfg_data;
                    bcc_pkg::CFG_TICK_PERIOD:    tick_period_reg    <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (advance)
            begin
                prescale_reg <= prescale_next;
                year_reg     <= year_next;
                year_mod_reg <= year_mod_next;
                month_reg    <= month_next;
                weekday_reg  <= weekday_next;
                day_reg      <= day_next;
                hour_reg     <= hour_next;
                minute_reg   <= minute_next;
                second_reg   <= second_next;
            end
        end
    end

    assign cal_valid    = cal_valid_reg;
    assign cal.year_mod = year_mod_reg;
    assign cal.month    = month_reg;
    assign cal.weekday  = weekday_reg;
    assign cal.day      = day_reg;
    assign cal.hour     = hour_reg;
    assign cal.minute   = minute_reg;
    assign cal.second   = second_reg;

endmodule

>>> hw/rtl/bcc_bcd_out.sv
// BCD formatting and result register of the BCD calendar clock.
module bcc_bcd_out (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cal_valid,
    input  bcc_pkg::cal_t cal,
    output logic          out_ready,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bcc_pkg::rsp_t rsp
);

    logic          rsp_valid_reg;
    logic          rsp_valid_next;
    bcc_pkg::rsp_t rsp_reg;
    bcc_pkg::rsp_t rsp_next;
    logic          load;

    assign out_ready      = !rsp_valid_reg || !rsp_stall;
    assign load           = cal_valid && out_ready;
    assign rsp_valid_next = load || (rsp_valid_reg && rsp_stall);

    always_comb
    begin
        rsp_next.year_bcd   = bcc_pkg::to_bcd({1'b0, cal.year_mod});
        rsp_next.month_week = {cal.month, cal.weekday};
        rsp_next.day_bcd    = bcc_pkg::to_bcd({1'b0, cal.day});
        rsp_next.hour_bcd   = bcc_pkg::to_bcd({1'b0, cal.hour});
        rsp_next.minute_bcd = bcc_pkg::to_bcd(cal.minute);
        rsp_next.second_bcd = bcc_pkg::to_bcd(cal.second);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the BCD calendar clock: directed and random requests against a predictor.
module tb_top;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int DRAIN_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [9:0] cfg_data = '0;
    logic req_valid = 1'b0;
    logic req_stall;
    bcc_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    bcc_pkg::rsp_t rsp;

    // calendar predictor state
    logic [9:0] tick_inc = bcc_pkg::TICK_INCREMENT_RESET;
    logic [9:0] tick_per = bcc_pkg::TICK_PERIOD_RESET;
    logic [10:0] prescale = '0;
    logic [15:0] cal_year = bcc_pkg::YEAR_RESET;
    logic [3:0] cal_month = 4'd1;
    logic [3:0] cal_wday = 4'd0;
    logic [6:0] cal_day = 7'd1;
    logic [6:0] cal_hour = 7'd0;
    logic [7:0] cal_min = 8'd0;
    logic [7:0] cal_sec = 8'd0;

    bcc_pkg::rsp_t pending_times[$];
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    bcd_calendar_clock dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always #1 clk = ~clk;

    function automatic int decode_digits(input logic [7:0] b);
        return int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    function automatic logic [7:0] encode_digits(input int v);
        int b;
        b = v & 255;
        return 8'(((b / 10) << 4) + b % 10);
    endfunction

    function automatic int month_length(input logic [3:0] m, input logic [15:0] y);
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 31;
            4'd2: return (y[1:0] == 2'b00) ? 29 : 28;
            default: return 30;
        endcase
    endfunction

    // compares use the full value, so out-of-range fields roll over
    function automatic void advance_second();
        int nxt;
        int lim;
        nxt = int'(cal_sec) + 1;
        if (nxt < 60)
        begin
            cal_sec = 8'(nxt);
            return;
        end
        cal_sec = '0;
        nxt = int'(cal_min) + 1;
        if (nxt < 60)
        begin
            cal_min = 8'(nxt);
            return;
        end
        cal_min = '0;
        nxt = int'(cal_hour) + 1;
        if (nxt < 24)
        begin
            cal_hour = 7'(nxt);
            return;
        end
        cal_hour = '0;
        lim = month_length(cal_month, cal_year);
        cal_wday = 4'((int'(cal_wday) + 1) % 7);
        nxt = int'(cal_day) + 1;
        if (nxt <= lim)
        begin
            cal_day = 7'(nxt);
            return;
        end
        cal_day = 7'd1;
        nxt = int'(cal_month) + 1;
        if (nxt <= 12)
        begin
            cal_month = 4'(nxt);
            return;
        end
        cal_month = 4'd1;
        cal_year = cal_year + 16'd1;
    endfunction

    function automatic bcc_pkg::rsp_t step_calendar(input bcc_pkg::req_t r);
        int sum;
        int yr;
        bcc_pkg::rsp_t t;
        case (r.cmd)
            bcc_pkg::CMD_TICK:
            begin
                sum = int'(prescale) + int'(tick_inc);
                if (sum >= int'(tick_per))
                begin
                    prescale = 11'(sum - int'(tick_per));
                    advance_second();
                end
                else
                    prescale = 11'(sum);
            end
            bcc_pkg::CMD_SET:
            begin
                yr = 1900 + decode_digits(r.set_year_bcd);
                if (yr < 1980)
                    yr += 100;
                cal_year = 16'(yr);
                cal_month = r.set_month_week[7:4];
                cal_wday = r.set_month_week[3:0];
                cal_day = 7'(decode_digits(r.set_day_bcd));
                cal_hour = 7'(decode_digits(r.set_hour_bcd));
                cal_min = 8'(decode_digits(r.set_minute_bcd));
                cal_sec = 8'(decode_digits(r.set_second_bcd));
            end
            default: ;
        endcase
        t.year_bcd = encode_digits(int'(cal_year) % 100);
        t.month_week = {cal_month, cal_wday};
        t.day_bcd = encode_digits(int'(cal_day));
        t.hour_bcd = encode_digits(int'(cal_hour));
        t.minute_bcd = encode_digits(int'(cal_min));
        t.second_bcd = encode_digits(int'(cal_sec));
        return t;
    endfunction

    // set fields are random; they only matter on a set
    function automatic bcc_pkg::req_t op_request(input logic [1:0] c);
        bcc_pkg::req_t r;
        r.cmd = c;
        r.set_year_bcd = 8'($urandom);
        r.set_month_week = 8'($urandom);
        r.set_day_bcd = 8'($urandom);
        r.set_hour_bcd = 8'($urandom);
        r.set_minute_bcd = 8'($urandom);
        r.set_second_bcd = 8'($urandom);
        return r;
    endfunction

    function automatic bcc_pkg::req_t set_request(input logic [7:0] y, mw, d, h, mi, s);
        bcc_pkg::req_t r;
        r.cmd = bcc_pkg::CMD_SET;
        r.set_year_bcd = y;
        r.set_month_week = mw;
        r.set_day_bcd = d;
        r.set_hour_bcd = h;
        r.set_minute_bcd = mi;
        r.set_second_bcd = s;
        return r;
    endfunction

    function automatic bcc_pkg::req_t random_request();
        bcc_pkg::req_t r;
        int pick;
        int yy;
        logic [3:0] mon;
        pick = $urandom_range(99);
        r = op_request(pick < 65 ? bcc_pkg::CMD_TICK : pick < 80 ? bcc_pkg::CMD_SET :
                       pick < 92 ? bcc_pkg::CMD_READ : CMD_UNUSED);
        if (r.cmd == bcc_pkg::CMD_SET && $urandom_range(99) < 75)
        begin
            yy = $urandom_range(99);
            mon = 4'($urandom_range(12, 1));
            r.set_year_bcd = encode_digits(yy);
            r.set_month_week = {mon, 4'($urandom_range(6))};
            if ($urandom_range(1) == 1)
            begin
                // just short of a month boundary
                r.set_day_bcd = encode_digits(month_length(mon, 16'(yy)) -
                                              int'($urandom_range(1)));
                r.set_hour_bcd = 8'h23;
                r.set_minute_bcd = 8'h59;
                r.set_second_bcd = encode_digits($urandom_range(59, 50));
            end
            else
            begin
                r.set_day_bcd = encode_digits($urandom_range(28, 1));
                r.set_hour_bcd = encode_digits($urandom_range(23));
                r.set_minute_bcd = encode_digits($urandom_range(59));
                r.set_second_bcd = encode_digits($urandom_range(59));
            end
        end
        return r;
    endfunction

    // called and returns just after a falling edge
    task automatic send_request(input bcc_pkg::req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (req_stall);
        pending_times.push_back(step_calendar(r));
        @(negedge clk);
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (pending_times.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [9:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        if (idx == bcc_pkg::CFG_TICK_INCREMENT)
            tick_inc = val;
        else
            tick_per = val;
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
    endtask

    task automatic test_reset_state();
        send_request(op_request(bcc_pkg::CMD_READ));
        repeat (3) send_request(op_request(bcc_pkg::CMD_TICK));
    endtask

    task automatic test_rollover_cases();
        wait_idle();
        write_reg(bcc_pkg::CFG_TICK_INCREMENT, 10'd1023);
        write_reg(bcc_pkg::CFG_TICK_PERIOD, 10'd1023);
        send_request(set_request(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_request(op_request(bcc_pkg::CMD_TICK));
        send_request(set_request(8'h99, 8'hC6, 8'h31, 8'h23, 8'h59, 8'h59));
        send_request(op_request(bcc_pkg::CMD_TICK));
        send_request(set_request(8'h96, 8'h24, 8'h28, 8'h23, 8'h59, 8'h59));
        send_request(op_request(bcc_pkg::CMD_TICK));
        send_request(set_request(8'h97, 8'h23, 8'h28, 8'h23, 8'h59, 8'h59));
        send_request(op_request(bcc_pkg::CMD_TICK));
        send_request(set_request(8'h00, 8'h25, 8'h29, 8'h23, 8'h59, 8'h59));
        send_request(op_request(bcc_pkg::CMD_TICK));
        // every byte all ones: wide values roll over
        send_request(set_request(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_request(op_request(bcc_pkg::CMD_TICK));
        // month zero: 30 days, no year step
        send_request(set_request(8'h50, 8'h03, 8'h30, 8'h23, 8'h59, 8'h59));
        send_request(op_request(bcc_pkg::CMD_TICK));
        // month 13: wraps to January of the next year
        send_request(set_request(8'h79, 8'hD1, 8'h30, 8'h23, 8'h59, 8'h59));
        send_request(op_request(bcc_pkg::CMD_TICK));
        send_request(set_request(8'h80, 8'hF2, 8'h07, 8'h23, 8'h59, 8'h59));
        send_request(op_request(bcc_pkg::CMD_TICK));
        // digits above nine
        send_request(set_request(8'h9A, 8'h1B, 8'hAA, 8'hBC, 8'hDE, 8'hF0));
        send_request(op_request(CMD_UNUSED));
        send_request(op_request(bcc_pkg::CMD_READ));
    endtask

    task automatic test_random_traffic(input int count, input logic [9:0] inc,
                                       input logic [9:0] per);
        wait_idle();
        write_reg(bcc_pkg::CFG_TICK_INCREMENT, inc);
        write_reg(bcc_pkg::CFG_TICK_PERIOD, per);
        repeat (count) send_request(random_request());
    endtask

    task automatic test_result_backpressure();
        set_idling(0, 0);
        hold_requests++;
        repeat (40) send_request(random_request());
    endtask

    always @(negedge clk)
    begin
        if (hold_left == 0 && hold_served != hold_requests)
        begin
            hold_served++;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin : result_check
        bcc_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_times.size() == 0)
            begin
                $error("result with no request outstanding");
                error_count++;
            end
            else
            begin
                want = pending_times.pop_front();
                if (rsp.year_bcd !== want.year_bcd)
                begin
                    $error("year_bcd: expected %02h, got %02h", want.year_bcd, rsp.year_bcd);
                    error_count++;
                end
                if (rsp.month_week !== want.month_week)
                begin
                    $error("month_week: expected %02h, got %02h",
                           want.month_week, rsp.month_week);
                    error_count++;
                end
                if (rsp.day_bcd !== want.day_bcd)
                begin
                    $error("day_bcd: expected %02h, got %02h", want.day_bcd, rsp.day_bcd);
                    error_count++;
                end
                if (rsp.hour_bcd !== want.hour_bcd)
                begin
                    $error("hour_bcd: expected %02h, got %02h", want.hour_bcd, rsp.hour_bcd);
                    error_count++;
                end
                if (rsp.minute_bcd !== want.minute_bcd)
                begin
                    $error("minute_bcd: expected %02h, got %02h",
                           want.minute_bcd, rsp.minute_bcd);
                    error_count++;
                end
                if (rsp.second_bcd !== want.second_bcd)
                begin
                    $error("second_bcd: expected %02h, got %02h",
                           want.second_bcd, rsp.second_bcd);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_idling(17, 82);
        test_reset_state();
        test_rollover_cases();
        test_random_traffic(350, 10'd1023, 10'd1023);
        set_idling(82, 17);
        test_random_traffic(300, 10'd1, 10'd1023);
        test_random_traffic(250, 10'd517, 10'd0);
        set_idling(0, 0);
        test_random_traffic(250, 10'd1023, 10'd1);
        test_random_traffic(200, bcc_pkg::TICK_INCREMENT_RESET, bcc_pkg::TICK_PERIOD_RESET);
        test_result_backpressure();
        wait_idle();
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("Verification failed");
        $finish;
    end

endmodule
